@@ rtl/core/cabs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cabs_pkg: shared types and constants for class-aware box suppression
// Transaction payloads, stored entry layout, register indexes and reset values.
// ----------------------------------------------------------------------------
package cabs_pkg;

    localparam int MAX_KEPT_DEF = 256;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEPT  = 1'b1;

    localparam logic [7:0] IOU_LIMIT_RESET = 8'd115;
    localparam logic [8:0] MAX_KEPT_RESET  = 9'd256;

    typedef struct packed {
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_right;
        logic [15:0] box_bottom;
        logic [6:0]  box_class;
        logic [15:0] box_score;
        logic        last_in_frame;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_left;
        logic [15:0] out_top;
        logic [15:0] out_right;
        logic [15:0] out_bottom;
        logic [6:0]  out_class;
        logic [15:0] out_score;
        logic [7:0]  out_rank;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  cls;
        logic [15:0] bottom;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] left;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/core/cabs_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cabs_store: kept box memory
// Single-port-per-direction synchronous memory of kept boxes and classes,
// with registered read data and a read-valid flag.
// ----------------------------------------------------------------------------
module cabs_store #(
    parameter int MAX_KEPT = cabs_pkg::MAX_KEPT_DEF,
    parameter int AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire cabs_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output cabs_pkg::entry_t     rd_data,
    output logic                 rd_valid
);

    cabs_pkg::entry_t mem [MAX_KEPT];
    cabs_pkg::entry_t rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule
`default_nettype wire

@@ rtl/core/cabs_iou.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cabs_iou: pipelined overlap test
// Four-stage pipeline that decides whether a stored box of the same class
// overlaps the candidate with IoU strictly above the threshold.
// ----------------------------------------------------------------------------
module cabs_iou (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       iou_limit,
    input  wire cabs_pkg::entry_t cand,
    input  wire logic             ent_valid,
    input  wire cabs_pkg::entry_t ent,
    output logic                  hit_valid,
    output logic                  hit,
    output logic                  busy
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic               match1_reg, pos1_reg;
    logic [15:0]        iw1_reg, ih1_reg;
    logic signed [16:0] wa1_reg, ha1_reg, wb1_reg, hb1_reg;

    logic               match2_reg, pos2_reg;
    logic [31:0]        inter2_reg;
    logic signed [33:0] area_a2_reg, area_b2_reg;

    logic               match3_reg, pos3_reg;
    logic [31:0]        inter3_reg;
    logic signed [35:0] uni3_reg;

    logic               hit4_reg;

    logic [15:0]        ix1, iy1, ix2, iy2;
    logic signed [16:0] iw, ih;
    logic               uni_pos;
    logic [39:0]        lhs;
    logic [42:0]        rhs;

    always_comb
    begin
        ix1 = (ent.left > cand.left) ? ent.left : cand.left;
        iy1 = (ent.top > cand.top) ? ent.top : cand.top;
        ix2 = (ent.right < cand.right) ? ent.right : cand.right;
        iy2 = (ent.bottom < cand.bottom) ? ent.bottom : cand.bottom;
        iw  = $signed({1'b0, ix2}) - $signed({1'b0, ix1});
        ih  = $signed({1'b0, iy2}) - $signed({1'b0, iy1});
    end

    always_comb
    begin
        uni_pos = !uni3_reg[35] && (uni3_reg != 36'sd0);
        lhs     = {inter3_reg, 8'h00};
        rhs     = iou_limit * uni3_reg[34:0];
    end

    always_ff @(posedge clk)
    begin
        match1_reg <= (ent.cls == cand.cls);
        pos1_reg   <= (iw > 17'sd0) && (ih > 17'sd0);
        iw1_reg    <= iw[15:0];
        ih1_reg    <= ih[15:0];
        wa1_reg    <= $signed({1'b0, ent.right}) - $signed({1'b0, ent.left});
        ha1_reg    <= $signed({1'b0, ent.bottom}) - $signed({1'b0, ent.top});
        wb1_reg    <= $signed({1'b0, cand.right}) - $signed({1'b0, cand.left});
        hb1_reg    <= $signed({1'b0, cand.bottom}) - $signed({1'b0, cand.top});

        match2_reg  <= match1_reg;
        pos2_reg    <= pos1_reg;
        inter2_reg  <= iw1_reg * ih1_reg;
        area_a2_reg <= wa1_reg * ha1_reg;
        area_b2_reg <= wb1_reg * hb1_reg;

        match3_reg <= match2_reg;
        pos3_reg   <= pos2_reg;
        inter3_reg <= inter2_reg;
        uni3_reg   <= 36'(area_a2_reg) + 36'(area_b2_reg) - $signed({4'b0000, inter2_reg});

        hit4_reg <= match3_reg && pos3_reg && uni_pos && ({3'b000, lhs} > rhs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ent_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign hit_valid = v4_reg;
    assign hit       = hit4_reg;
    assign busy      = v1_reg || v2_reg || v3_reg || v4_reg;

endmodule
`default_nettype wire

@@ rtl/core/cabs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cabs_ctrl: suppression sequencer
// Holds the configuration, the candidate box, the kept count and the frame
// state, scans the store one entry per cycle and drives the output register.
// ----------------------------------------------------------------------------
module cabs_ctrl #(
    parameter int MAX_KEPT = cabs_pkg::MAX_KEPT_DEF,
    parameter int AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire cabs_pkg::in_item_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output cabs_pkg::out_item_t                out_data,
    input  wire logic                          cfg_we,
    input  wire logic [cabs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cabs_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [7:0]                         iou_limit,
    output cabs_pkg::entry_t                   cand,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  wire logic                          rd_valid,
    input  wire logic                          hit_valid,
    input  wire logic                          hit,
    input  wire logic                          pipe_busy
);

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int LW = (CW > 9) ? CW : 9;

    cabs_pkg::state_t    state_reg, state_next;
    logic [7:0]          iou_limit_reg;
    logic [8:0]          max_kept_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic                full_reg, full_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic                hit_acc_reg;
    cabs_pkg::entry_t    cand_reg;
    logic [15:0]         score_reg;
    logic                last_reg;
    logic                out_valid_reg;
    cabs_pkg::out_item_t out_data_reg;

    logic                accept;
    logic                out_free;
    logic                keep;
    logic [LW-1:0]       limit;
    logic [LW-1:0]       count_ext;
    logic [LW-1:0]       max_kept_ext;

    assign accept       = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign count_ext    = LW'(count_reg);
    assign max_kept_ext = LW'(max_kept_reg);
    assign limit        = (max_kept_ext < LW'(MAX_KEPT)) ? max_kept_ext : LW'(MAX_KEPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iou_limit_reg <= cabs_pkg::IOU_LIMIT_RESET;
            max_kept_reg  <= cabs_pkg::MAX_KEPT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cabs_pkg::CFG_IOU_LIMIT: iou_limit_reg <= cfg_data[7:0];
                cabs_pkg::CFG_MAX_KEPT:  max_kept_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        full_next  = full_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        keep       = 1'b0;

        unique case (state_reg)
            cabs_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    if (full_reg || (count_ext >= limit))
                    begin
                        full_next = 1'b1;
                        if (in_data.last_in_frame)
                        begin
                            count_next = '0;
                            full_next  = 1'b0;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = cabs_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        state_next = cabs_pkg::ST_SCAN;
                    end
                end
            end
            cabs_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
                if (CW'(idx_reg) == count_reg - CW'(1))
                begin
                    state_next = cabs_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            cabs_pkg::ST_DRAIN:
            begin
                if (!rd_valid && !pipe_busy)
                begin
                    state_next = cabs_pkg::ST_DECIDE;
                end
            end
            cabs_pkg::ST_DECIDE:
            begin
                if (hit_acc_reg || out_free)
                begin
                    state_next = cabs_pkg::ST_IDLE;
                    if (!hit_acc_reg)
                    begin
                        keep       = 1'b1;
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (last_reg)
                    begin
                        count_next = '0;
                        full_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = cabs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cabs_pkg::ST_IDLE;
            count_reg     <= '0;
            full_reg      <= 1'b0;
            idx_reg       <= '0;
            hit_acc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            full_reg  <= full_next;
            idx_reg   <= idx_next;
            if (accept)
            begin
                hit_acc_reg <= 1'b0;
            end
            else if (hit_valid && hit)
            begin
                hit_acc_reg <= 1'b1;
            end
            if (keep)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_reg.left   <= in_data.box_left;
            cand_reg.top    <= in_data.box_top;
            cand_reg.right  <= in_data.box_right;
            cand_reg.bottom <= in_data.box_bottom;
            cand_reg.cls    <= in_data.box_class;
            score_reg       <= in_data.box_score;
            last_reg        <= in_data.last_in_frame;
        end
        if (keep)
        begin
            out_data_reg.out_left   <= cand_reg.left;
            out_data_reg.out_top    <= cand_reg.top;
            out_data_reg.out_right  <= cand_reg.right;
            out_data_reg.out_bottom <= cand_reg.bottom;
            out_data_reg.out_class  <= cand_reg.cls;
            out_data_reg.out_score  <= score_reg;
            out_data_reg.out_rank   <= count_ext[7:0];
        end
    end

    assign in_stall  = (state_reg != cabs_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign iou_limit = iou_limit_reg;
    assign cand      = cand_reg;
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_addr   = idx_reg;

endmodule
`default_nettype wire

@@ rtl/core/class_aware_box_suppression.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A box that meets an empty list goes from acceptance straight to the decide
// state; otherwise the store is scanned one stored entry per cycle and the
// overlap pipeline drains first. A new box is accepted only once the last is
// decided, so the pace is set by the single read port of the kept box memory
// and the overlap pipeline drain. Boxes at a full list are dropped while idle.
// Reset clears control state and presets the configuration, not data or memory.
// ----------------------------------------------------------------------------
// class_aware_box_suppression: greedy class-aware non-maximum suppression
// Keeps, up to the keep limit, boxes that no kept box of the same class overlaps
// above the IoU threshold and emits each kept box with its rank in the frame.
// ----------------------------------------------------------------------------
module class_aware_box_suppression #(
    parameter int MAX_KEPT = cabs_pkg::MAX_KEPT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire cabs_pkg::in_item_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output cabs_pkg::out_item_t                  out_data,
    input  wire logic                            cfg_we,
    input  wire logic [cabs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cabs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    logic [7:0]       iou_limit;
    cabs_pkg::entry_t cand;
    cabs_pkg::entry_t rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             rd_valid;
    logic             hit_valid;
    logic             hit;
    logic             pipe_busy;

    cabs_ctrl #(
        .MAX_KEPT (MAX_KEPT),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .iou_limit (iou_limit),
        .cand      (cand),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_valid  (rd_valid),
        .hit_valid (hit_valid),
        .hit       (hit),
        .pipe_busy (pipe_busy)
    );

    cabs_store #(
        .MAX_KEPT (MAX_KEPT),
        .AW       (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (cand),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    cabs_iou u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .iou_limit (iou_limit),
        .cand      (cand),
        .ent_valid (rd_valid),
        .ent       (rd_data),
        .hit_valid (hit_valid),
        .hit       (hit),
        .busy      (pipe_busy)
    );

endmodule
`default_nettype wire

@@ verif/tb_class_aware_box_suppression.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_class_aware_box_suppression: self-checking bench for class-aware NMS
// Drives box transactions with bursty timing and checks every kept box, in
// order, against an in-bench model of greedy class-aware suppression, across
// threshold and keep-limit settings including the extremes.
// ----------------------------------------------------------------------------
module tb_class_aware_box_suppression;
    import cabs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int SETTLE_CYCLES  = 300;
    localparam int MAX_PRINTS     = 40;

    typedef struct packed {
        logic [15:0] lft;
        logic [15:0] top;
        logic [15:0] rgt;
        logic [15:0] bot;
    } rect_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IOU_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Model state.
    rect_t kept_rect [MAX_KEPT_DEF];
    logic [6:0] kept_cls [MAX_KEPT_DEF];
    int kept_n = 0;
    bit list_full = 1'b0;
    logic [7:0] iou_q8 = IOU_LIMIT_RESET;
    logic [8:0] keep_cap = MAX_KEPT_RESET;

    in_item_t box_queue[$];
    out_item_t expected_keeps[$];

    int boxes_queued = 0;
    int boxes_accepted = 0;
    int keeps_checked = 0;
    int boxes_dropped = 0;
    int frames_closed = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    int burst_left = 0;
    int gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int mode_left = 0;
    int stall_tick = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic hold_armed = 1'b0;
    out_item_t want;

    class_aware_box_suppression DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit iou_exceeds(rect_t a, rect_t b);
        longint al, at, ar, ab, bl, bt, br, bb;
        longint iw, ih, inter, uni, thr;
        al = a.lft;
        at = a.top;
        ar = a.rgt;
        ab = a.bot;
        bl = b.lft;
        bt = b.top;
        br = b.rgt;
        bb = b.bot;
        thr = iou_q8;
        iw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
        ih = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
        if (iw <= 0 || ih <= 0)
            return 1'b0;
        inter = iw * ih;
        uni = (ar - al) * (ab - at) + (br - bl) * (bb - bt) - inter;
        if (uni <= 0)
            return 1'b0;
        return (inter * 256) > (thr * uni);
    endfunction

    task automatic suppress_step(input in_item_t it);
        int cap;
        bit hit;
        rect_t r;
        out_item_t res;
        r.lft = it.box_left;
        r.top = it.box_top;
        r.rgt = it.box_right;
        r.bot = it.box_bottom;
        cap = (keep_cap < MAX_KEPT_DEF) ? int'(keep_cap) : MAX_KEPT_DEF;
        if (kept_n >= cap)
            list_full = 1'b1;
        hit = 1'b1;
        if (!list_full)
        begin
            hit = 1'b0;
            for (int i = 0; i < kept_n && !hit; i++)
                if (kept_cls[i] == it.box_class && iou_exceeds(kept_rect[i], r))
                    hit = 1'b1;
        end
        if (!hit)
        begin
            kept_rect[kept_n] = r;
            kept_cls[kept_n] = it.box_class;
            res.out_left = it.box_left;
            res.out_top = it.box_top;
            res.out_right = it.box_right;
            res.out_bottom = it.box_bottom;
            res.out_class = it.box_class;
            res.out_score = it.box_score;
            res.out_rank = kept_n[7:0];
            expected_keeps.push_back(res);
            kept_n++;
        end
        else
            boxes_dropped++;
        if (it.last_in_frame)
        begin
            kept_n = 0;
            list_full = 1'b0;
            frames_closed++;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %h expected %h (rank %0d)",
                                      name, got, exp_val, want.out_rank));
    endtask

    function automatic logic [15:0] clamp16(input int v);
        if (v < 0)
            return 16'h0000;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    task automatic queue_box(input int l, input int t, input int r, input int b,
                             input int cls, input int score, input bit last);
        in_item_t it;
        it.box_left = clamp16(l);
        it.box_top = clamp16(t);
        it.box_right = clamp16(r);
        it.box_bottom = clamp16(b);
        it.box_class = cls[6:0];
        it.box_score = score[15:0];
        it.last_in_frame = last;
        box_queue.push_back(it);
        boxes_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IOU_LIMIT: iou_q8 = val[7:0];
            CFG_MAX_KEPT:  keep_cap = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic settle();
        while (boxes_accepted != boxes_queued)
            @(posedge clk);
        while (expected_keeps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Clustered boxes of a few classes so that suppression happens often.
    task automatic queue_scene(input int n_boxes, input int jitter, output int made);
        int cx[4], cy[4], cw[4], ch[4], cc[4];
        int n_clusters, k, score, jl, jt, jr, jb;
        n_clusters = $urandom_range(1, 4);
        for (int c = 0; c < 4; c++)
        begin
            cw[c] = $urandom_range(16, 4000);
            ch[c] = $urandom_range(16, 4000);
            cx[c] = $urandom_range(0, 65535 - cw[c]);
            cy[c] = $urandom_range(0, 65535 - ch[c]);
            cc[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 3);
        end
        score = $urandom_range(40000, 65535);
        for (int i = 0; i < n_boxes; i++)
        begin
            k = $urandom_range(0, n_clusters - 1);
            jl = int'($urandom_range(0, 2 * jitter)) - jitter;
            jt = int'($urandom_range(0, 2 * jitter)) - jitter;
            jr = int'($urandom_range(0, 2 * jitter)) - jitter;
            jb = int'($urandom_range(0, 2 * jitter)) - jitter;
            queue_box(cx[k] + jl, cy[k] + jt, cx[k] + cw[k] + jr, cy[k] + ch[k] + jb,
                      cc[k], score, i == n_boxes - 1);
            score = (score > 1500) ? score - int'($urandom_range(0, 1500)) : 0;
        end
        made = n_boxes;
    endtask

    task automatic queue_noise(input int n);
        for (int i = 0; i < n; i++)
            queue_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 127), $urandom_range(0, 65535),
                      $urandom_range(0, 9) == 0);
    endtask

    // Sender: bursts of transactions separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                suppress_step(in_data);
                boxes_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (box_queue.size() != 0)
                begin
                    in_data <= box_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 3);
                            2: gap_left = $urandom_range(4, 30);
                            default: gap_left = $urandom_range(31, 300);
                        endcase
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off once armed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_tick++;
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(30, 400);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_armed && !hold_done && out_valid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                case (stall_mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
                    default:     out_stall <= ((stall_tick % 5) < 2);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_keeps.size() == 0)
                report_mismatch($sformatf("unexpected transaction, rank %0d class %0d",
                                          out_data.out_rank, out_data.out_class));
            else
            begin
                want = expected_keeps.pop_front();
                check_field("out_left", out_data.out_left, want.out_left);
                check_field("out_top", out_data.out_top, want.out_top);
                check_field("out_right", out_data.out_right, want.out_right);
                check_field("out_bottom", out_data.out_bottom, want.out_bottom);
                check_field("out_class", 16'(out_data.out_class), 16'(want.out_class));
                check_field("out_score", out_data.out_score, want.out_score);
                check_field("out_rank", 16'(out_data.out_rank), 16'(want.out_rank));
                keeps_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("class_aware_box_suppression verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int made, total, iou_sel, cap_sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: duplicates, class separation, touching, inverted,
        // degenerate and full-range boxes, and the end of frame on a dropped box.
        queue_box(0, 0, 640, 640, 3, 65535, 1'b0);
        queue_box(0, 0, 640, 640, 3, 65000, 1'b0);
        queue_box(0, 0, 640, 640, 4, 64000, 1'b0);
        queue_box(320, 0, 960, 640, 3, 63000, 1'b0);
        queue_box(640, 0, 1280, 640, 3, 62000, 1'b0);
        queue_box(1280, 1280, 0, 0, 3, 61000, 1'b0);
        queue_box(100, 100, 100, 100, 3, 60000, 1'b0);
        queue_box(0, 0, 65535, 65535, 127, 50000, 1'b0);
        queue_box(0, 0, 65535, 65535, 127, 40000, 1'b0);
        queue_box(65535, 65535, 65535, 65535, 80, 0, 1'b0);
        queue_box(0, 0, 640, 640, 3, 0, 1'b1);
        queue_box(0, 0, 640, 640, 3, 12345, 1'b1);
        settle();

        // IoU of exactly one half sits on the threshold at 128 and above it at 127.
        write_reg(CFG_IOU_LIMIT, 9'd128);
        queue_box(0, 0, 200, 100, 1, 9000, 1'b0);
        queue_box(0, 0, 100, 100, 1, 8000, 1'b1);
        settle();
        write_reg(CFG_IOU_LIMIT, 9'd127);
        queue_box(0, 0, 200, 100, 1, 9000, 1'b0);
        queue_box(0, 0, 100, 100, 1, 8000, 1'b1);
        settle();

        write_reg(CFG_IOU_LIMIT, 9'd0);
        queue_box(1000, 1000, 2000, 2000, 7, 30000, 1'b0);
        queue_box(1999, 1999, 3000, 3000, 7, 29000, 1'b0);
        queue_box(2000, 2000, 3000, 3000, 7, 28000, 1'b1);
        settle();

        write_reg(CFG_IOU_LIMIT, 9'd255);
        queue_box(1000, 1000, 2000, 2000, 7, 30000, 1'b0);
        queue_box(1000, 1000, 2000, 2000, 7, 29000, 1'b0);
        queue_box(1001, 1000, 2000, 2000, 7, 28000, 1'b1);
        settle();

        write_reg(CFG_MAX_KEPT, 9'd1);
        queue_box(0, 0, 100, 100, 2, 500, 1'b0);
        queue_box(200, 0, 300, 100, 2, 400, 1'b0);
        queue_box(400, 0, 500, 100, 2, 300, 1'b1);
        queue_box(400, 0, 500, 100, 2, 300, 1'b1);
        settle();

        write_reg(CFG_MAX_KEPT, 9'd0);
        queue_box(0, 0, 100, 100, 2, 500, 1'b0);
        queue_box(200, 0, 300, 100, 5, 400, 1'b1);
        settle();

        // One full frame: disjoint boxes fill the list, the rest are dropped.
        write_reg(CFG_MAX_KEPT, 9'd300);
        write_reg(CFG_IOU_LIMIT, 9'd115);
        for (int k = 0; k < 262; k++)
            queue_box((k % 16) * 4000, (k / 16) * 3500, (k % 16) * 4000 + 3000,
                      (k / 16) * 3500 + 3000, $urandom_range(0, 79), 65535 - k * 200,
                      k == 261);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            iou_sel = $urandom_range(0, 3);
            cap_sel = $urandom_range(0, 4);
            if (ph == 0)
                cap_sel = 1;
            else if (ph == 1)
                cap_sel = 2;
            write_reg(CFG_IOU_LIMIT, (iou_sel == 0) ? 9'd0 :
                                     (iou_sel == 1) ? 9'd255 :
                                     (iou_sel == 2) ? 9'd115 : 9'($urandom_range(1, 254)));
            write_reg(CFG_MAX_KEPT, (cap_sel == 0) ? 9'd1 :
                                    (cap_sel == 1) ? 9'd256 :
                                    (cap_sel == 2) ? 9'd511 : 9'($urandom_range(2, 24)));
            if (ph == 2)
            begin
                @(posedge clk);
                hold_armed <= 1'b1;
            end
            total = 0;
            while (total < 100)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    case ($urandom_range(0, 2))
                        0: queue_scene($urandom_range(1, 20), 4, made);
                        1: queue_scene($urandom_range(1, 20), 40, made);
                        default: queue_scene($urandom_range(1, 20), 400, made);
                    endcase
                end
                else
                begin
                    made = $urandom_range(1, 6);
                    queue_noise(made);
                end
                total += made;
            end
            settle();
        end

        if (expected_keeps.size() != 0)
            report_mismatch($sformatf("%0d expected transactions never arrived",
                                      expected_keeps.size()));
        $display("Run covered %0d boxes in %0d closed frames: %0d kept and checked, %0d dropped.",
                 boxes_accepted, frames_closed, keeps_checked, boxes_dropped);
        $display("Register writes: %0d, thresholds 0..255 and keep limits 0..511; %0d mismatches.",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("class_aware_box_suppression verification clean");
        else
            $display("class_aware_box_suppression verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cabs_pkg.sv
rtl/core/cabs_store.sv
rtl/core/cabs_iou.sv
rtl/core/cabs_ctrl.sv
rtl/core/class_aware_box_suppression.sv
verif/tb_class_aware_box_suppression.sv
